/* hw/rtl/slle_pkg.sv */
`default_nettype none

package slle_pkg;

    localparam int unsigned POS_W = 10;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned LEN_W = 10;
    localparam int unsigned STS_W = 2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam logic [STS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STS_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STS_W-1:0] ST_NO_SLOT = 2'd2;

    typedef struct packed {
        logic                    req_type;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [LEN_W-1:0] list_length;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_INS_SLOT,
        S_INS_NXT,
        S_WALK_DATA,
        S_INS_LINK,
        S_DEL_V,
        S_DEL_F,
        S_DEL_H,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic             idle;
        logic             done;
        logic             inc;
        logic             dec;
        logic [STS_W-1:0] status;
    } t_seq_ctl;

endpackage

`default_nettype wire

/* hw/rtl/slle_ram.sv */
`default_nettype none

module slle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

/* hw/rtl/slle_seq.sv */
`default_nettype none

module slle_seq import slle_pkg::*; #(
    parameter int SLOT_COUNT = 1024,
    localparam int IW = $clog2(SLOT_COUNT)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire t_in_item      i_item,
    input  wire logic [IW-1:0] i_count,
    input  wire logic          i_grant,
    output t_seq_ctl           o_ctl
);

    localparam int PW = ((IW > POS_W) ? IW : POS_W) + 1;
    localparam logic [IW-1:0] HEAD = IW'(SLOT_COUNT - 1);

    t_state r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;
    logic             r_type, n_type;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [VAL_W-1:0] r_value, n_value;
    logic [IW-1:0]    r_prev, n_prev;
    logic [IW-1:0]    r_steps, n_steps;
    logic [IW-1:0]    r_slot, n_slot;
    logic [STS_W-1:0] r_status, n_status;

    logic          w_link_we;
    logic [IW-1:0] w_link_wa;
    logic [IW-1:0] w_link_wd;
    logic [IW-1:0] w_link_ra;
    logic [IW-1:0] w_link_rd;
    logic          w_elem_we;

    logic [PW-1:0] w_pos_ext;
    logic [PW-1:0] w_limit;
    logic          w_bad_pos;
    logic          w_slot_bad;
    logic          w_walk_end;

    assign w_pos_ext  = PW'(r_pos);
    assign w_limit    = (r_type == REQ_INSERT) ? PW'(i_count) + PW'(1) : PW'(i_count);
    assign w_bad_pos  = (w_pos_ext == '0) || (w_pos_ext > w_limit);
    assign w_slot_bad = (w_link_rd == '0) || (w_link_rd >= HEAD);
    assign w_walk_end = (r_steps == '0);

    slle_ram #(
        .WIDTH(IW),
        .DEPTH(SLOT_COUNT)
    ) u_link_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_link_we),
        .i_wr_addr(w_link_wa),
        .i_wr_data(w_link_wd),
        .i_rd_addr(w_link_ra),
        .o_rd_data(w_link_rd)
    );

    slle_ram #(
        .WIDTH(VAL_W),
        .DEPTH(SLOT_COUNT)
    ) u_elem_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_elem_we),
        .i_wr_addr(w_link_rd),
        .i_wr_data(r_value),
        .i_rd_addr(w_link_rd),
        .o_rd_data()
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_idx == HEAD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (w_bad_pos) begin
                    n_state = S_RESULT;
                end else if (r_type == REQ_INSERT) begin
                    n_state = S_INS_SLOT;
                end else begin
                    n_state = S_WALK_DATA;
                end
            end
            S_INS_SLOT: begin
                n_state = w_slot_bad ? S_RESULT : S_INS_NXT;
            end
            S_INS_NXT: begin
                n_state = S_WALK_DATA;
            end
            S_WALK_DATA: begin
                if (w_walk_end) begin
                    n_state = (r_type == REQ_INSERT) ? S_INS_LINK : S_DEL_V;
                end
            end
            S_INS_LINK: begin
                n_state = S_RESULT;
            end
            S_DEL_V: begin
                n_state = S_DEL_F;
            end
            S_DEL_F: begin
                n_state = S_DEL_H;
            end
            S_DEL_H: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_grant) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_link_we = 1'b0;
        w_link_wa = r_prev;
        w_link_wd = w_link_rd;
        w_link_ra = r_prev;
        w_elem_we = 1'b0;
        o_ctl     = '0;
        n_idx     = r_idx;
        n_type    = r_type;
        n_pos     = r_pos;
        n_value   = r_value;
        n_prev    = r_prev;
        n_steps   = r_steps;
        n_slot    = r_slot;
        n_status  = r_status;
        case (r_state)
            S_CLEAR: begin
                w_link_we = 1'b1;
                w_link_wa = r_idx;
                w_link_wd = (r_idx == HEAD) ? '0 : r_idx + IW'(1);
                n_idx     = r_idx + IW'(1);
            end
            S_IDLE: begin
                o_ctl.idle = 1'b1;
                if (i_start) begin
                    n_type  = i_item.req_type;
                    n_pos   = i_item.position;
                    n_value = i_item.element_value;
                end
            end
            S_DECODE: begin
                n_prev    = HEAD;
                n_steps   = IW'(w_pos_ext - PW'(1));
                n_status  = w_bad_pos ? ST_BAD_POS : ST_OK;
                w_link_ra = (r_type == REQ_INSERT) ? '0 : HEAD;
            end
            S_INS_SLOT: begin
                if (w_slot_bad) begin
                    n_status = ST_NO_SLOT;
                end else begin
                    n_slot    = w_link_rd;
                    w_link_ra = w_link_rd;
                    w_elem_we = 1'b1;
                end
            end
            S_INS_NXT: begin
                w_link_we = 1'b1;
                w_link_wa = '0;
                w_link_ra = HEAD;
            end
            S_WALK_DATA: begin
                if (!w_walk_end) begin
                    n_prev    = w_link_rd;
                    n_steps   = r_steps - IW'(1);
                    w_link_ra = w_link_rd;
                end else if (r_type == REQ_INSERT) begin
                    w_link_we = 1'b1;
                    w_link_wa = r_slot;
                end else begin
                    n_slot    = w_link_rd;
                    w_link_ra = w_link_rd;
                end
            end
            S_INS_LINK: begin
                w_link_we = 1'b1;
                w_link_wd = r_slot;
                o_ctl.inc = 1'b1;
            end
            S_DEL_V: begin
                w_link_we = 1'b1;
                w_link_ra = '0;
            end
            S_DEL_F: begin
                w_link_we = 1'b1;
                w_link_wa = r_slot;
            end
            S_DEL_H: begin
                w_link_we = 1'b1;
                w_link_wa = '0;
                w_link_wd = r_slot;
                o_ctl.dec = 1'b1;
            end
            S_RESULT: begin
                o_ctl.done   = 1'b1;
                o_ctl.status = r_status;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
        r_type   <= n_type;
        r_pos    <= n_pos;
        r_value  <= n_value;
        r_prev   <= n_prev;
        r_steps  <= n_steps;
        r_slot   <= n_slot;
        r_status <= n_status;
    end

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_DATA && w_walk_end) |=> (r_state != S_WALK_DATA))
        else $error("walk did not stop at its target node");

    a_victim_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL_H) |-> (r_slot != '0 && r_slot != HEAD))
        else $error("a list head was returned to the free list");

    a_no_self_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_LINK) |-> (r_prev != r_slot))
        else $error("insert splices a slot after itself");

    a_result_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.done && i_grant) |=> o_ctl.idle)
        else $error("sequencer did not return to idle after its result");

endmodule

`default_nettype wire

/* hw/rtl/static_linked_list_engine_core.sv */
// Channel   Direction  Signals                              Beat
// request   in         i_in_valid, o_in_ready, i_in_data    one insert or delete
// result    out        o_out_valid, i_out_ready, o_out_data one status and length
//
// A request walks the list up to its position, reading one link per cycle on
// the single read port of the link memory.
// After reset a clearing pass builds the free list, and no request is taken
// during it.
// Reset is synchronous and active low.
// A pending result holds the sequencer in its last step until it is taken.
`default_nettype none

module static_linked_list_engine_core import slle_pkg::*; #(
    parameter int SLOT_COUNT = 1024
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    localparam int IW = $clog2(SLOT_COUNT);

    t_seq_ctl      w_ctl;
    logic          w_grant;
    logic [IW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    assign w_grant     = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_ctl.idle;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    slle_seq #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_in_valid && w_ctl.idle),
        .i_item (i_in_data),
        .i_count(r_count),
        .i_grant(w_grant),
        .o_ctl  (w_ctl)
    );

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_ctl.inc) begin
            n_count = r_count + IW'(1);
        end else if (w_ctl.dec) begin
            n_count = r_count - IW'(1);
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_ctl.done && w_grant) begin
            n_out_valid       = 1'b1;
            n_out.status      = w_ctl.status;
            n_out.list_length = LEN_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IW'(SLOT_COUNT - 2))
        else $error("element count exceeds the usable slots");

endmodule

`default_nettype wire

/* tb/static_linked_list_engine_core_tb.sv */
`default_nettype none

module static_linked_list_engine_core_tb;
    import slle_pkg::*;

    localparam int SLOT_COUNT = 1024;
    localparam logic [POS_W-1:0] HEAD_SLOT = POS_W'(SLOT_COUNT - 1);
    localparam int MAX_ELEMENTS = SLOT_COUNT - 2;
    localparam int RANDOM_ITEMS = 580;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 60;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        bit               typed;
        logic [STS_W-1:0] sts;
        logic [LEN_W-1:0] len;
    } t_plan_row;

    localparam int PLAN_ROWS = 21;
    localparam t_plan_row DIRECTED_PLAN [PLAN_ROWS] = '{
        '{REQ_DELETE, 10'd1,    32'h0000_0000, 1'b1, ST_BAD_POS, 10'd0},
        '{REQ_INSERT, 10'd0,    32'h0000_0000, 1'b1, ST_BAD_POS, 10'd0},
        '{REQ_INSERT, 10'd2,    32'h0000_0005, 1'b1, ST_BAD_POS, 10'd0},
        '{REQ_INSERT, 10'd1023, 32'hFFFF_FFFF, 1'b1, ST_BAD_POS, 10'd0},
        '{REQ_DELETE, 10'd1023, 32'h0000_0000, 1'b1, ST_BAD_POS, 10'd0},
        '{REQ_INSERT, 10'd1,    32'h7FFF_FFFF, 1'b1, ST_OK,      10'd1},
        '{REQ_INSERT, 10'd2,    32'h8000_0000, 1'b1, ST_OK,      10'd2},
        '{REQ_INSERT, 10'd1,    32'hFFFF_FFFF, 1'b1, ST_OK,      10'd3},
        '{REQ_INSERT, 10'd4,    32'h0000_0000, 1'b1, ST_OK,      10'd4},
        '{REQ_INSERT, 10'd3,    32'h1234_5678, 1'b0, ST_OK,      10'd0},
        '{REQ_INSERT, 10'd7,    32'h0000_0000, 1'b1, ST_BAD_POS, 10'd5},
        '{REQ_DELETE, 10'd6,    32'h0000_0000, 1'b1, ST_BAD_POS, 10'd5},
        '{REQ_DELETE, 10'd0,    32'h0000_0000, 1'b1, ST_BAD_POS, 10'd5},
        '{REQ_DELETE, 10'd3,    32'hDEAD_BEEF, 1'b0, ST_OK,      10'd0},
        '{REQ_DELETE, 10'd4,    32'h0000_0000, 1'b1, ST_OK,      10'd3},
        '{REQ_DELETE, 10'd1,    32'h0000_0000, 1'b1, ST_OK,      10'd2},
        '{REQ_INSERT, 10'd2,    32'h5555_5555, 1'b0, ST_OK,      10'd0},
        '{REQ_DELETE, 10'd2,    32'h0000_0000, 1'b1, ST_OK,      10'd2},
        '{REQ_DELETE, 10'd2,    32'h0000_0000, 1'b1, ST_OK,      10'd1},
        '{REQ_DELETE, 10'd1,    32'h0000_0000, 1'b1, ST_OK,      10'd0},
        '{REQ_DELETE, 10'd1,    32'h0000_0000, 1'b1, ST_BAD_POS, 10'd0}
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    int        sender_idle_pct = 0;
    int        receiver_stall_pct = 0;
    bit        hold_request = 1'b0;
    bit        hold_taken = 1'b0;
    int        hold_left = 0;
    int        mismatch_count = 0;

    logic [POS_W-1:0] link_mem [SLOT_COUNT];
    int unsigned      list_count;
    t_out_item        pending_results [$];

    static_linked_list_engine_core #(
        .SLOT_COUNT(SLOT_COUNT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("static_linked_list_engine_core_tb NOT OK");
        $finish;
    end

    function automatic logic [POS_W-1:0] walk_links(int unsigned steps);
        logic [POS_W-1:0] node;
        node = HEAD_SLOT;
        repeat (steps) node = link_mem[node];
        return node;
    endfunction

    // Applies one request to the shadow list and returns the result it gives.
    function automatic t_out_item apply_list_request(t_in_item req);
        logic [POS_W-1:0] slot;
        logic [POS_W-1:0] prev;
        logic [POS_W-1:0] victim;
        int unsigned      pos;
        t_out_item        res;
        pos = 32'(req.position);
        res.status = ST_OK;
        if (req.req_type == REQ_INSERT) begin
            if (pos < 1 || pos > list_count + 1) begin
                res.status = ST_BAD_POS;
            end else begin
                slot = link_mem[0];
                if (slot == 0 || slot >= HEAD_SLOT) begin
                    res.status = ST_NO_SLOT;
                end else begin
                    link_mem[0] = link_mem[slot];
                    prev = walk_links(pos - 1);
                    link_mem[slot] = link_mem[prev];
                    link_mem[prev] = slot;
                    list_count++;
                end
            end
        end else begin
            if (pos < 1 || pos > list_count) begin
                res.status = ST_BAD_POS;
            end else begin
                prev = walk_links(pos - 1);
                victim = link_mem[prev];
                link_mem[prev] = link_mem[victim];
                link_mem[victim] = link_mem[0];
                link_mem[0] = victim;
                list_count--;
            end
        end
        res.list_length = LEN_W'(list_count);
        return res;
    endfunction

    function automatic t_in_item pick_random_request();
        t_in_item req;
        int       insert_pct;
        int       top;
        req.element_value = $urandom;
        if ($urandom_range(99) < 12) begin
            req.req_type = 1'($urandom_range(1));
            req.position = POS_W'($urandom_range(1023));
            return req;
        end
        if (list_count == 0) begin
            insert_pct = 100;
        end else if (list_count >= 120) begin
            insert_pct = 30;
        end else begin
            insert_pct = 55;
        end
        req.req_type = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_DELETE;
        top = (req.req_type == REQ_INSERT) ? int'(list_count) + 1 : int'(list_count);
        case ($urandom_range(9))
            0: begin
                req.position = POS_W'(1);
            end
            1: begin
                req.position = POS_W'(top);
            end
            default: begin
                req.position = POS_W'($urandom_range(top, 1));
            end
        endcase
        return req;
    endfunction

    task automatic offer_request(input t_in_item req, input bit typed,
                                 input t_out_item typed_res);
        t_out_item predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_list_request(req);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic offer_predicted(input logic kind, input int unsigned pos);
        t_in_item req;
        req.req_type = kind;
        req.position = POS_W'(pos);
        req.element_value = $urandom;
        offer_request(req, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with none expected: status %0d length %0d",
                         $time, o_out_data.status, o_out_data.list_length);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_out_data.status);
                    mismatch_count++;
                end
                if (o_out_data.list_length !== want.list_length) begin
                    $display("%0t: list_length expected %0d actual %0d",
                             $time, want.list_length, o_out_data.list_length);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        t_in_item  req;
        t_out_item res;
        int        phase;
        int        top;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            link_mem[i] = POS_W'(i + 1);
        end
        link_mem[HEAD_SLOT] = '0;
        list_count = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++) begin
            req.req_type = DIRECTED_PLAN[i].kind;
            req.position = DIRECTED_PLAN[i].pos;
            req.element_value = DIRECTED_PLAN[i].val;
            res.status = DIRECTED_PLAN[i].sts;
            res.list_length = DIRECTED_PLAN[i].len;
            offer_request(req, DIRECTED_PLAN[i].typed, res);
        end
        wait_drained();

        // Fill the list to capacity with cheap inserts near the head.
        sender_idle_pct <= 56;
        while (list_count < MAX_ELEMENTS) begin
            top = (list_count + 1 < 8) ? list_count + 1 : 8;
            offer_predicted(REQ_INSERT, $urandom_range(top, 1));
        end
        wait_drained();

        sender_idle_pct <= 0;
        offer_predicted(REQ_INSERT, 1);
        offer_predicted(REQ_INSERT, 1023);
        offer_predicted(REQ_INSERT, 0);
        offer_predicted(REQ_DELETE, 1023);
        offer_predicted(REQ_DELETE, MAX_ELEMENTS);
        offer_predicted(REQ_INSERT, MAX_ELEMENTS);
        offer_predicted(REQ_DELETE, 512);
        offer_predicted(REQ_INSERT, 1023);
        wait_drained();

        sender_idle_pct <= 0;
        receiver_stall_pct <= 56;
        while (list_count > 16) begin
            top = (list_count < 4) ? list_count : 4;
            offer_predicted(REQ_DELETE, $urandom_range(top, 1));
        end
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            phase = i / (RANDOM_ITEMS / 4);
            if (i % (RANDOM_ITEMS / 4) == 0) begin
                case (phase)
                    0: begin
                        sender_idle_pct <= 0;
                        receiver_stall_pct <= 0;
                        hold_request <= 1'b1;
                    end
                    1: begin
                        sender_idle_pct <= 56;
                        receiver_stall_pct <= 0;
                    end
                    2: begin
                        sender_idle_pct <= 0;
                        receiver_stall_pct <= 56;
                    end
                    default: begin
                        sender_idle_pct <= 38;
                        receiver_stall_pct <= 38;
                    end
                endcase
            end
            offer_request(pick_random_request(), 1'b0, '0);
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("static_linked_list_engine_core_tb OK");
        end else begin
            $display("static_linked_list_engine_core_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
